@@ src/dhwt_pkg.sv @@
// Shared types, constants and defaults of the double-hash word table.
package dhwt_pkg;

	// Fixed field widths
	localparam int CHAR_W       = 5;
	localparam int WORD_CHARS   = 6;
	localparam int WORD_W       = CHAR_W * WORD_CHARS;
	localparam int LEN_W        = 3;
	localparam int CFG_W        = 9;
	localparam int STATUS_W     = 2;
	localparam int INDEX_W      = 8;
	localparam int FUNC_W       = 1;
	localparam int ENTRY_W      = LEN_W + WORD_W;

	// Longest word taken; longer lengths are clipped to this
	localparam int MAX_CHARS    = 6;

	// Hash: base-27 polynomial, fits 29 bits even with codes up to 31
	localparam int HASH_BASE    = 27;
	localparam int HASH_W       = 29;
	localparam int NBITS_W      = $clog2(HASH_W + 1);

	// Defaults
	localparam int TABLE_DEPTH_DEF    = 256;
	localparam int STEP_MODULUS_DEF   = 23;
	localparam int ACTIVE_SLOTS_RESET = 200;

	// Request codes
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED  = 2'd0,
		ST_FOUND   = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_REM,
		S_STEP,
		S_READ,
		S_CHECK,
		S_FIN
	} state_t;

	// Command to the remainder unit
	typedef struct packed {
		logic               start;
		logic [NBITS_W-1:0] nbits;
	} rem_cmd_t;

endpackage

@@ src/dhwt_if.sv @@
// Handshake channel interfaces: request, response and configuration write.
interface dhwt_req_if;
	import dhwt_pkg::*;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [WORD_W-1:0] word_chars;
	logic [LEN_W-1:0]  word_length;
	modport source (output valid, output func, output word_chars, output word_length,
		input ready);
	modport sink (input valid, input func, input word_chars, input word_length,
		output ready);
endinterface

interface dhwt_rsp_if;
	import dhwt_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  slot_index;
	modport source (output valid, output status, output slot_index, input ready);
	modport sink (input valid, input status, input slot_index, output ready);
endinterface

interface dhwt_cfg_if;
	import dhwt_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] active_slots;
	modport source (output valid, output active_slots, input ready);
	modport sink (input valid, input active_slots, output ready);
endinterface

@@ src/dhwt_rem.sv @@
// Bit-serial restoring remainder unit, two divisors side by side.
module dhwt_rem #(
	parameter int NW = 9,
	parameter int MW = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dhwt_pkg::rem_cmd_t            cmd,
	input  logic [dhwt_pkg::HASH_W-1:0]   dividend,
	input  logic [NW-1:0]                 div_a,
	input  logic [MW-1:0]                 div_b,
	output logic                          done,
	output logic [NW-1:0]                 rem_a,
	output logic [MW-1:0]                 rem_b
);
	import dhwt_pkg::*;

	logic [HASH_W-1:0]  sh_q;
	logic [NW-1:0]      ra_q;
	logic [MW-1:0]      rb_q;
	logic [NBITS_W-1:0] cnt_q;
	logic               run_q;
	logic               done_q;

	logic [NW:0] ta;
	logic [MW:0] tb;
	logic [NW-1:0] ra_n;
	logic [MW-1:0] rb_n;

	// shift next dividend bit in, subtract if it fits
	always_comb begin
		ta = {ra_q, sh_q[HASH_W-1]};
		tb = {rb_q, sh_q[HASH_W-1]};
		if (ta >= {1'b0, div_a}) begin
			ra_n = NW'(ta - {1'b0, div_a});
		end else begin
			ra_n = NW'(ta);
		end
		if (tb >= {1'b0, div_b}) begin
			rb_n = MW'(tb - {1'b0, div_b});
		end else begin
			rb_n = MW'(tb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= cmd.nbits;
		end else if (run_q) begin
			cnt_q <= cnt_q - NBITS_W'(1);
			if (cnt_q == NBITS_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sh_q <= dividend;
			ra_q <= '0;
			rb_q <= '0;
		end else if (run_q) begin
			sh_q <= sh_q << 1;
			ra_q <= ra_n;
			rb_q <= rb_n;
		end
	end

	assign done  = done_q;
	assign rem_a = ra_q;
	assign rem_b = rb_q;

endmodule

@@ src/double_hash_word_table.sv @@
// Double-hash word table: insert or search short words in an open-addressed slot store.
// Sequence: the Horner hash over the letters, two remainder passes, then one slot read plus
//   one compare per probe before the response beat. Ready only when idle: the next request
//   is taken in the cycle after the response is loaded, later while a response is held.
// Reset: arst_n asynchronous, active low. After release a clearing pass empties every slot
//   in turn; requests wait, configuration writes are taken throughout.
module double_hash_word_table #(
	parameter int TABLE_DEPTH  = dhwt_pkg::TABLE_DEPTH_DEF,
	parameter int STEP_MODULUS = dhwt_pkg::STEP_MODULUS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	dhwt_cfg_if.sink   cfg,
	dhwt_req_if.sink   req,
	dhwt_rsp_if.source rsp
);
	import dhwt_pkg::*;

	localparam int KW = $clog2(TABLE_DEPTH);      // slot address
	localparam int NW = $clog2(TABLE_DEPTH + 1);  // slot count 1..TABLE_DEPTH
	localparam int MW = $clog2(STEP_MODULUS + 1); // probe step 1..STEP_MODULUS

	// ---------------------------------------------------------------
	// Configuration: one register, always ready
	// ---------------------------------------------------------------
	logic [CFG_W-1:0] active_slots_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slots_q <= CFG_W'(ACTIVE_SLOTS_RESET);
		end else if (cfg.valid) begin
			active_slots_q <= cfg.active_slots;
		end
	end

	// Slots in use: zero acts as one, clipped to the store depth
	logic [NW-1:0] n_slots;
	always_comb begin
		if (active_slots_q == '0) begin
			n_slots = NW'(1);
		end else if (int'(active_slots_q) > TABLE_DEPTH) begin
			n_slots = NW'(TABLE_DEPTH);
		end else begin
			n_slots = NW'(active_slots_q);
		end
	end

	// ---------------------------------------------------------------
	// Request capture: clip length, zero the unused characters
	// ---------------------------------------------------------------
	logic [LEN_W-1:0]  req_len;
	logic [WORD_W-1:0] req_word;
	always_comb begin
		if (int'(req.word_length) > MAX_CHARS) begin
			req_len = LEN_W'(MAX_CHARS);
		end else begin
			req_len = req.word_length;
		end
		req_word = req.word_chars & ~({WORD_W{1'b1}} >> (CHAR_W * int'(req_len)));
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	state_t state_q, state_n;

	logic [FUNC_W-1:0] func_q;
	logic [LEN_W-1:0]  len_q;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] chars_q;    // shifted out one letter per Horner step
	logic [LEN_W-1:0]  cnt_q;
	logic [HASH_W-1:0] hash_q;
	logic [KW-1:0]     key_q;
	logic [NW-1:0]     stepn_q;    // probe step reduced mod slot count
	logic [KW-1:0]     probe_q;
	logic [KW-1:0]     clr_q;
	logic [ENTRY_W-1:0] rd_q;
	status_t           res_status_q;
	logic [KW-1:0]     res_idx_q;
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [INDEX_W-1:0] rsp_idx_q;

	// remainder unit
	rem_cmd_t          rem_cmd;
	logic [HASH_W-1:0] rem_dividend;
	logic              rem_done;
	logic [NW-1:0]     rem_a;
	logic [MW-1:0]     rem_b;
	logic [MW-1:0]     step_c;

	// memory port
	logic               mem_we;
	logic               mem_re;
	logic [KW-1:0]      mem_wa;
	logic [ENTRY_W-1:0] mem_wd;
	logic [ENTRY_W-1:0] slot_mem [TABLE_DEPTH];

	// probe decision
	logic [LEN_W-1:0]  rd_len;
	logic [WORD_W-1:0] rd_word;
	logic              slot_empty;
	logic              slot_match;
	logic              last_probe;
	logic              walk_stop;
	logic              hash_last;
	logic              clr_last;
	logic              rsp_free;
	logic [NW:0]       key_sum;
	logic [KW-1:0]     key_next;
	status_t           status_c;
	logic [KW-1:0]     idx_c;

	assign rd_len     = rd_q[ENTRY_W-1 -: LEN_W];
	assign rd_word    = rd_q[WORD_W-1:0];
	assign slot_empty = (rd_len == '0);
	// an empty word is never reported found: occupied slots have a length of one or more
	assign slot_match = (rd_len == len_q) && (rd_word == word_q);
	assign last_probe = (probe_q == KW'(n_slots - NW'(1)));
	assign walk_stop  = (func_q == FUNC_INSERT) ? slot_empty : (slot_empty || slot_match);
	assign hash_last  = (cnt_q == len_q);
	assign clr_last   = (clr_q == KW'(TABLE_DEPTH - 1));
	assign rsp_free   = !rsp_valid_q || rsp.ready;

	// step = M - (hash mod M), taken straight off the unit when it finishes
	assign step_c = MW'(STEP_MODULUS) - rem_b;

	// next slot: key + step, one conditional subtract keeps it below the count
	always_comb begin
		key_sum = (NW + 1)'(key_q) + (NW + 1)'(stepn_q);
		if (key_sum >= (NW + 1)'(n_slots)) begin
			key_sum = key_sum - (NW + 1)'(n_slots);
		end
		key_next = KW'(key_sum);
	end

	// outcome of the current probe
	always_comb begin
		status_c = (func_q == FUNC_INSERT) ? ST_FULL : ST_MISSING;
		idx_c    = '0;
		priority if (func_q == FUNC_INSERT && slot_empty) begin
			status_c = ST_STORED;
			idx_c    = key_q;
		end else if (func_q == FUNC_SEARCH && !slot_empty && slot_match) begin
			status_c = ST_FOUND;
			idx_c    = key_q;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (req.valid) state_n = S_HASH;
			end
			S_HASH: begin
				if (hash_last) state_n = S_REM;
			end
			S_REM: begin
				if (rem_done) state_n = S_STEP;
			end
			S_STEP: begin
				if (rem_done) state_n = S_READ;
			end
			S_READ: begin
				state_n = S_CHECK;
			end
			S_CHECK: begin
				if (walk_stop || last_probe) begin
					state_n = S_FIN;
				end else begin
					state_n = S_READ;
				end
			end
			S_FIN: begin
				if (rsp_free) state_n = S_IDLE;
			end
			default: state_n = S_CLEAR;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready     = 1'b0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_wa        = key_q;
		mem_wd        = {len_q, word_q};
		rem_cmd.start = 1'b0;
		rem_cmd.nbits = NBITS_W'(HASH_W);
		rem_dividend  = hash_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			S_IDLE: begin
				req.ready = 1'b1;
			end
			S_HASH: begin
				rem_cmd.start = hash_last;
			end
			S_REM: begin
				// second pass through the unit: step mod slot count
				rem_cmd.start = rem_done;
				rem_cmd.nbits = NBITS_W'(MW);
				rem_dividend  = {step_c, {(HASH_W - MW){1'b0}}};
			end
			S_READ: begin
				mem_re = 1'b1;
			end
			S_CHECK: begin
				// empty word: reported stored, the slot stays empty as length is zero
				mem_we = (func_q == FUNC_INSERT) && slot_empty;
			end
			S_STEP, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_CLEAR) clr_q <= clr_q + KW'(1);
			if (state_q == S_FIN && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				func_q  <= req.func;
				len_q   <= req_len;
				word_q  <= req_word;
				chars_q <= req_word;
				cnt_q   <= '0;
				hash_q  <= '0;
			end
			S_HASH: begin
				if (!hash_last) begin
					// Horner step: hash*27 + next letter
					hash_q  <= HASH_W'(hash_q * HASH_W'(HASH_BASE)
						+ HASH_W'(chars_q[WORD_W-1 -: CHAR_W]));
					chars_q <= chars_q << CHAR_W;
					cnt_q   <= cnt_q + LEN_W'(1);
				end
			end
			S_REM: begin
				if (rem_done) key_q <= KW'(rem_a);
			end
			S_STEP: begin
				if (rem_done) begin
					stepn_q <= rem_a;
					probe_q <= '0;
				end
			end
			S_CHECK: begin
				res_status_q <= status_c;
				res_idx_q    <= idx_c;
				key_q        <= key_next;
				probe_q      <= probe_q + KW'(1);
			end
			S_FIN: begin
				if (rsp_free) begin
					rsp_status_q <= res_status_q;
					rsp_idx_q    <= INDEX_W'(res_idx_q);
				end
			end
			S_CLEAR, S_READ: begin
			end
			default: begin
			end
		endcase
	end

	// slot store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) slot_mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= slot_mem[key_q];
	end

	dhwt_rem #(
		.NW (NW),
		.MW (MW)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (rem_cmd),
		.dividend (rem_dividend),
		.div_a    (n_slots),
		.div_b    (MW'(STEP_MODULUS)),
		.done     (rem_done),
		.rem_a    (rem_a),
		.rem_b    (rem_b)
	);

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.slot_index = rsp_idx_q;

endmodule

@@ bench/tb_double_hash_word_table.sv @@
`timescale 1ns / 100ps
// Self-checking bench for double_hash_word_table: directed and random requests against a table model.
module tb_double_hash_word_table;
	import dhwt_pkg::*;

	localparam int     CLK_PERIOD     = 20;
	localparam int     RESET_CYCLES   = 12;
	localparam int     DEPTH          = TABLE_DEPTH_DEF;
	localparam int     RANDOM_ITEMS   = 900;
	localparam int     PHASES         = 10;
	localparam int     POOL_MAX       = 64;
	// drain comfortably beyond the longest probe walk
	localparam int     DRAIN_CYCLES   = 600;
	// ~920 requests at their longest walk each, plus clearing pass, four times over
	localparam longint TIMEOUT_CYCLES = 2500000;

	// Table model plus the queue of responses still owed by the block.
	class word_table_board;
		logic [WORD_W-1:0]  slot_word [DEPTH];
		logic [LEN_W-1:0]   slot_len  [DEPTH];
		logic [CFG_W-1:0]   active_slots;
		status_t            expected_status [$];
		logic [INDEX_W-1:0] expected_slot [$];
		int                 errors;

		function new();
			for (int i = 0; i < DEPTH; i++) begin
				slot_word[i] = '0;
				slot_len[i]  = '0;
			end
			active_slots = CFG_W'(ACTIVE_SLOTS_RESET);
			errors = 0;
		endfunction

		function void set_slots(logic [CFG_W-1:0] value);
			active_slots = value;
		endfunction

		function int pending();
			return expected_status.size();
		endfunction

		// Probe walk for one accepted request; updates the table on insert.
		function void note_request(logic [FUNC_W-1:0] func, logic [WORD_W-1:0] chars,
				logic [LEN_W-1:0] len);
			int unsigned        n, key, step, hash, probe, clen;
			logic [WORD_W-1:0]  word;
			logic [CHAR_W-1:0]  c;
			status_t            st;
			logic [INDEX_W-1:0] idx;
			bit                 done;
			clen = (len > MAX_CHARS) ? MAX_CHARS : len;
			hash = 0;
			word = '0;
			for (int i = 0; i < clen; i++) begin
				c = chars[WORD_W-1-CHAR_W*i -: CHAR_W];
				hash = hash * HASH_BASE + c;
				word[WORD_W-1-CHAR_W*i -: CHAR_W] = c;
			end
			if (active_slots == 0)
				n = 1;
			else if (active_slots > DEPTH)
				n = DEPTH;
			else
				n = active_slots;
			key   = hash % n;
			step  = STEP_MODULUS_DEF - (hash % STEP_MODULUS_DEF);
			st    = (func == FUNC_SEARCH) ? ST_MISSING : ST_FULL;
			idx   = '0;
			done  = 1'b0;
			probe = 0;
			while (!done && probe < n) begin
				if (func == FUNC_INSERT) begin
					// empty word lands here too, but leaves the slot empty
					if (slot_len[key] == 0) begin
						slot_word[key] = word;
						slot_len[key]  = LEN_W'(clen);
						st   = ST_STORED;
						idx  = INDEX_W'(key);
						done = 1'b1;
					end
				end else if (slot_len[key] == 0) begin
					done = 1'b1;
				end else if (slot_len[key] == clen && slot_word[key] == word) begin
					st   = ST_FOUND;
					idx  = INDEX_W'(key);
					done = 1'b1;
				end
				key = (key + step) % n;
				probe++;
			end
			expected_status.push_back(st);
			expected_slot.push_back(idx);
		endfunction

		function void check_result(logic [STATUS_W-1:0] status, logic [INDEX_W-1:0] slot_index);
			status_t            want_st;
			logic [INDEX_W-1:0] want_idx;
			if (expected_status.size() == 0) begin
				errors++;
				$display("%0t: stray response, expected none, actual status %0d slot %0d",
					$time, status, slot_index);
				return;
			end
			want_st  = expected_status.pop_front();
			want_idx = expected_slot.pop_front();
			if (status !== want_st) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, want_st, status);
			end
			if (slot_index !== want_idx) begin
				errors++;
				$display("%0t: slot_index expected %0d actual %0d", $time, want_idx, slot_index);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   no_idle;

	dhwt_cfg_if cfg_ch ();
	dhwt_req_if req_ch ();
	dhwt_rsp_if rsp_ch ();

	word_table_board board = new();

	// recently inserted words, replayed for hits and duplicates
	logic [WORD_W-1:0] pool_chars [$];
	logic [LEN_W-1:0]  pool_len   [$];

	double_hash_word_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("FAIL");
		$finish;
	end

	// Letters to codes, first letter in the top bits; space is code 0.
	function automatic logic [WORD_W-1:0] spell(string text);
		logic [WORD_W-1:0] w;
		logic [CHAR_W-1:0] c;
		w = '0;
		for (int i = 0; i < text.len() && i < WORD_CHARS; i++) begin
			c = (text[i] == " ") ? '0 : CHAR_W'(text[i] - "a" + 1);
			w[WORD_W-1-CHAR_W*i -: CHAR_W] = c;
		end
		return w;
	endfunction

	// Bits that belong to the valid characters of a word of this length.
	function automatic logic [WORD_W-1:0] live_bits(logic [LEN_W-1:0] len);
		logic [WORD_W-1:0] all_ones;
		int unsigned       clen;
		all_ones = '1;
		clen = (len > MAX_CHARS) ? MAX_CHARS : len;
		return ~(all_ones >> (CHAR_W * clen));
	endfunction

	// One request beat; the model is told at the edge that takes it.
	// valid stays high on exit so back-to-back beats need no extra edge.
	task automatic send_request(logic [FUNC_W-1:0] func, logic [WORD_W-1:0] chars,
			logic [LEN_W-1:0] len);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.func        <= func;
		req_ch.word_chars  <= chars;
		req_ch.word_length <= len;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		board.note_request(func, chars, len);
	endtask

	// Drop valid and wait until every owed response is in; block is idle then.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_slots(logic [CFG_W-1:0] value);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.active_slots <= value;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		board.set_slots(value);
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly plain a..z words; some clipped/empty lengths, raw bits, codes 27..31.
	task automatic random_word(output logic [WORD_W-1:0] chars, output logic [LEN_W-1:0] len);
		int mode;
		mode = $urandom_range(0, 9);
		len  = LEN_W'($urandom_range(1, MAX_CHARS));
		for (int i = 0; i < WORD_CHARS; i++)
			chars[WORD_W-1-CHAR_W*i -: CHAR_W] = CHAR_W'($urandom_range(1, 26));
		if (mode == 0)
			len = $urandom_range(0, 1) ? 3'd7 : 3'd0;
		else if (mode == 1)
			chars = WORD_W'($urandom);
		else if (mode == 2)
			for (int i = 0; i < WORD_CHARS; i++)
				chars[WORD_W-1-CHAR_W*i -: CHAR_W] = CHAR_W'($urandom_range(0, 31));
		// junk past the length must be ignored by the block
		chars = (chars & live_bits(len)) | (WORD_W'($urandom) & ~live_bits(len));
	endtask

	task automatic random_request();
		logic [FUNC_W-1:0] func;
		logic [WORD_W-1:0] chars;
		logic [LEN_W-1:0]  len;
		int                pick;
		func = ($urandom_range(0, 99) < 45) ? FUNC_INSERT : FUNC_SEARCH;
		if (pool_chars.size() > 0 &&
				$urandom_range(0, 99) < ((func == FUNC_SEARCH) ? 65 : 15)) begin
			// replay a known word with fresh junk below its length
			pick  = $urandom_range(0, pool_chars.size() - 1);
			len   = pool_len[pick];
			chars = (pool_chars[pick] & live_bits(len)) | (WORD_W'($urandom) & ~live_bits(len));
		end else begin
			random_word(chars, len);
		end
		if (func == FUNC_INSERT) begin
			pool_chars.push_back(chars);
			pool_len.push_back(len);
			if (pool_chars.size() > POOL_MAX) begin
				pool_chars.pop_front();
				pool_len.pop_front();
			end
		end
		send_request(func, chars, len);
	endtask

	// Response side: random stall before each beat, checked on the taking edge.
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (rsp_ch.valid !== 1'b1);
			board.check_result(rsp_ch.status, rsp_ch.slot_index);
		end
	end

	// Main sequence: reset, directed cases, then random phases at several slot counts.
	initial begin
		logic [CFG_W-1:0] phase_slots [PHASES];
		logic [WORD_W-1:0] odd_codes;
		phase_slots = '{9'd200, 9'd1, 9'd0, 9'd7, 9'd256, 9'd300, 9'd511, 9'd23, 9'd64, 9'd131};
		odd_codes   = {5'd27, 5'd28, 5'd29, 5'd30, 5'd31, 5'd0};

		arst_n                = 1'b0;
		no_idle               = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.func           = FUNC_INSERT;
		req_ch.word_chars     = '0;
		req_ch.word_length    = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.active_slots   = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// taken even during the clearing pass; requests simply wait on ready
		write_slots(CFG_W'(ACTIVE_SLOTS_RESET));

		// directed: empty table, empty word, longest word, clipping, junk bits
		send_request(FUNC_SEARCH, spell("cab"), 3'd3);
		send_request(FUNC_INSERT, '0, 3'd0);
		send_request(FUNC_SEARCH, '0, 3'd0);
		send_request(FUNC_INSERT, spell("zzzzzz"), 3'd6);
		send_request(FUNC_SEARCH, spell("zzzzzz"), 3'd6);
		send_request(FUNC_INSERT, spell("zzzzzz"), 3'd6);
		send_request(FUNC_INSERT, '1, 3'd7);
		send_request(FUNC_SEARCH, '1, 3'd6);
		send_request(FUNC_INSERT, spell("ab") | 30'h000F_FFFF, 3'd2);
		send_request(FUNC_SEARCH, spell("ab") | 30'h0005_5555, 3'd2);
		send_request(FUNC_SEARCH, spell("ab"), 3'd3);
		send_request(FUNC_INSERT, spell("      "), 3'd6);
		send_request(FUNC_SEARCH, spell("      "), 3'd6);
		send_request(FUNC_INSERT, odd_codes, 3'd5);
		send_request(FUNC_SEARCH, odd_codes, 3'd5);
		wait_drained();

		// single slot: fills at once, then full walks on insert and search
		write_slots(9'd1);
		send_request(FUNC_INSERT, spell("q"), 3'd1);
		send_request(FUNC_INSERT, spell("r"), 3'd1);
		send_request(FUNC_SEARCH, spell("s"), 3'd1);
		send_request(FUNC_INSERT, '0, 3'd0);
		send_request(FUNC_SEARCH, spell("zzzzzz"), 3'd6);

		// random phases; every third runs both sides without idling
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_slots(phase_slots[p]);
			no_idle = (p % 3 == 2);
			for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
				// now and then hold off until the block has answered everything
				if ($urandom_range(0, 39) == 0)
					wait_drained();
				random_request();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
